@@ hw/rtl/gthr_pkg.sv @@
// Shared types and constants for the two-hop graph reachability unit.
package gthr_pkg;

    // Fixed field widths of the transaction ports.
    localparam int ACTION_W = 2;
    localparam int NODE_W   = 6;
    localparam int CFG_W    = 7;

    // Node count after reset.
    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

    // Item action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

endpackage

@@ hw/rtl/graph_two_hop_reachability_unit.sv @@
// Two-hop reachability unit: adjacency memory, walk stack memory and the walk sequencer.
//
// Usage: the input channel (in_valid/in_ready) carries one transaction per item.
// An add-edge item writes one bit of the adjacency matrix, a clear item drops every
// edge, and a query item asks whether middle_node is reachable from start_node and
// end_node from middle_node. Only a query produces an output transaction on
// out_valid/out_ready, carrying path_exists and node_error. A query with a node at
// or above the node count (capped at MAX_NODES) returns node_error at once.
// A clear is done while idle; an add-edge reads the row, then writes it back. A query
// walks the graph through the stack memory and the adjacency memory: each reached node
// is pushed onto the stack, then popped with a read of its stack entry, and then its
// adjacency row is read. A walk stops early as soon as its target node is reached.
// One item is worked on at a time; in_ready is high only while the sequencer is idle.
// The finished result goes to an output register; if the receiver stalls, the unit
// holds the next result until that register is free. Reset clears all edges through
// per-row valid bits, sets the node count to 64 and empties the output register.
// The node count is written through cfg_we/cfg_wdata; the user must write it only while
// the unit is idle, since the unit itself has no check for this.
module graph_two_hop_reachability_unit
    import gthr_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [NODE_W-1:0]   edge_source,
    input  logic [NODE_W-1:0]   edge_dest,
    input  logic [NODE_W-1:0]   start_node,
    input  logic [NODE_W-1:0]   middle_node,
    input  logic [NODE_W-1:0]   end_node,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                path_exists,
    output logic                node_error
);

    localparam int NODE_IW = $clog2(MAX_NODES);
    localparam int DEP_W   = $clog2(MAX_NODES + 1);
    localparam int LIM_W   = (DEP_W > CFG_W) ? DEP_W : CFG_W;

    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [NODE_IW-1:0]   node_idx_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ADD    = 6'b000010,
        S_PUSH   = 6'b000100,
        S_FETCH  = 6'b001000,
        S_EXPAND = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    // Memories.
    row_t      adj_mem [MAX_NODES];
    node_idx_t stk_mem [MAX_NODES];

    // Registers.
    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  node_count_reg;
    row_t              row_valid_reg, row_valid_next;
    row_t              visited_reg, visited_next;
    row_t              pend_reg, pend_next;
    logic [DEP_W-1:0]  depth_reg, depth_next;
    node_idx_t         target_reg, target_next;
    node_idx_t         final_reg, final_next;
    logic              second_reg, second_next;
    node_idx_t         add_row_reg, add_row_next;
    node_idx_t         add_col_reg, add_col_next;
    logic              res_path_reg, res_path_next;
    logic              res_err_reg, res_err_next;
    logic              out_valid_reg, out_valid_next;
    logic              path_exists_reg, path_exists_next;
    logic              node_error_reg, node_error_next;
    row_t              adj_rdata_reg;
    logic              adj_rvalid_reg;
    node_idx_t         stk_rdata_reg;

    // Memory controls.
    logic      adj_we, adj_re;
    node_idx_t adj_waddr, adj_raddr;
    row_t      adj_wdata;
    logic      stk_we, stk_re;
    node_idx_t stk_waddr, stk_raddr;
    node_idx_t stk_wdata;

    // Helper values.
    logic [LIM_W-1:0] limit;
    row_t             lmask;
    row_t             adj_row;
    row_t             new_bits;
    node_idx_t        low_idx;
    logic             src_ok, dst_ok, x_ok, y_ok, z_ok;
    logic             in_fire;
    logic             hit;
    logic [DEP_W-1:0] depth_dec;

    // Node limit is the node count capped at the stored graph size.
    always_comb
    begin
        if (LIM_W'(node_count_reg) > LIM_W'(MAX_NODES))
        begin
            limit = LIM_W'(MAX_NODES);
        end
        else
        begin
            limit = LIM_W'(node_count_reg);
        end
    end

    // Mask of nodes below the limit, so stale edges are never followed.
    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            lmask[i] = (LIM_W'(i) < limit);
        end
    end

    assign src_ok = (LIM_W'(edge_source) < limit);
    assign dst_ok = (LIM_W'(edge_dest) < limit);
    assign x_ok   = (LIM_W'(start_node) < limit);
    assign y_ok   = (LIM_W'(middle_node) < limit);
    assign z_ok   = (LIM_W'(end_node) < limit);

    // A row that was never written since the last clear reads as empty.
    assign adj_row  = adj_rvalid_reg ? adj_rdata_reg : '0;
    assign new_bits = adj_row & ~visited_reg & lmask;

    // Lowest pending node, pushed next.
    always_comb
    begin
        low_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                low_idx = NODE_IW'(i);
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign hit       = visited_reg[target_reg];
    assign depth_dec = depth_reg - DEP_W'(1);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        row_valid_next   = row_valid_reg;
        visited_next     = visited_reg;
        pend_next        = pend_reg;
        depth_next       = depth_reg;
        target_next      = target_reg;
        final_next       = final_reg;
        second_next      = second_reg;
        add_row_next     = add_row_reg;
        add_col_next     = add_col_reg;
        res_path_next    = res_path_reg;
        res_err_next     = res_err_reg;
        out_valid_next   = out_valid_reg;
        path_exists_next = path_exists_reg;
        node_error_next  = node_error_reg;
        adj_we    = 1'b0;
        adj_waddr = add_row_reg;
        adj_wdata = adj_row | (row_t'(1) << add_col_reg);
        adj_re    = 1'b0;
        adj_raddr = NODE_IW'(edge_source);
        stk_we    = 1'b0;
        stk_waddr = depth_reg[NODE_IW-1:0];
        stk_wdata = low_idx;
        stk_re    = 1'b0;
        stk_raddr = depth_dec[NODE_IW-1:0];

        // The output register drains whenever the receiver takes the transaction.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        ACT_ADD:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                adj_re       = 1'b1;
                                add_row_next = NODE_IW'(edge_source);
                                add_col_next = NODE_IW'(edge_dest);
                                state_next   = S_ADD;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        ACT_QUERY:
                        begin
                            if (x_ok && y_ok && z_ok)
                            begin
                                visited_next = row_t'(1) << NODE_IW'(start_node);
                                pend_next    = row_t'(1) << NODE_IW'(start_node);
                                depth_next   = '0;
                                target_next  = NODE_IW'(middle_node);
                                final_next   = NODE_IW'(end_node);
                                second_next  = 1'b0;
                                state_next   = S_PUSH;
                            end
                            else
                            begin
                                res_path_next = 1'b0;
                                res_err_next  = 1'b1;
                                state_next    = S_RESULT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Write back the edge row with the new bit set.
            S_ADD:
            begin
                adj_we                      = 1'b1;
                row_valid_next[add_row_reg] = 1'b1;
                state_next                  = S_IDLE;
            end

            // End a walk (next hop or result), push one pending node, or pop the stack.
            S_PUSH:
            begin
                if (hit || ((pend_reg == '0) && (depth_reg == '0)))
                begin
                    if (!second_reg && hit)
                    begin
                        visited_next = row_t'(1) << target_reg;
                        pend_next    = row_t'(1) << target_reg;
                        depth_next   = '0;
                        target_next  = final_reg;
                        second_next  = 1'b1;
                    end
                    else
                    begin
                        res_path_next = hit;
                        res_err_next  = 1'b0;
                        state_next    = S_RESULT;
                    end
                end
                else if (pend_reg != '0)
                begin
                    stk_we             = 1'b1;
                    pend_next[low_idx] = 1'b0;
                    depth_next         = depth_reg + DEP_W'(1);
                end
                else
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_dec;
                    state_next = S_FETCH;
                end
            end

            // The popped node is available; read its adjacency row.
            S_FETCH:
            begin
                adj_re     = 1'b1;
                adj_raddr  = stk_rdata_reg;
                state_next = S_EXPAND;
            end

            // Mark unvisited neighbors below the limit and queue them for pushing.
            S_EXPAND:
            begin
                visited_next = visited_reg | new_bits;
                pend_next    = new_bits;
                state_next   = S_PUSH;
            end

            // Hand the result to the output register once it is free.
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    path_exists_next = res_path_reg;
                    node_error_next  = res_err_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            row_valid_reg  <= '0;
            depth_reg      <= '0;
            second_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            adj_rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            depth_reg     <= depth_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (adj_re)
            begin
                adj_rvalid_reg <= row_valid_reg[adj_raddr];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        visited_reg     <= visited_next;
        pend_reg        <= pend_next;
        target_reg      <= target_next;
        final_reg       <= final_next;
        add_row_reg     <= add_row_next;
        add_col_reg     <= add_col_next;
        res_path_reg    <= res_path_next;
        res_err_reg     <= res_err_next;
        path_exists_reg <= path_exists_next;
        node_error_reg  <= node_error_next;
    end

    // Adjacency memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rdata_reg <= adj_mem[adj_raddr];
        end
    end

    // Walk stack memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign path_exists = path_exists_reg;
    assign node_error  = node_error_reg;

endmodule

@@ dv/tb_graph_two_hop_reachability_unit.sv @@
// Self-checking testbench for the two-hop graph reachability unit.
module tb_graph_two_hop_reachability_unit;
    import gthr_pkg::*;

    localparam int NODES = 64;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    // Idle cycles before a register write, so a last add-edge item has finished.
    localparam int SETTLE_CYCLES = 20;
    // Quiet time at the end, longer than the slowest query.
    localparam int END_CYCLES = 600;

    typedef struct packed {
        logic path_exists;
        logic node_error;
    } reach_result_t;

    // Mirrors the graph and node count and keeps the expected query answers in order.
    class reach_scoreboard;
        logic [NODES-1:0] adj_rows [NODES];
        logic [CFG_W-1:0] node_count;
        reach_result_t    expected_q [$];
        int unsigned      fail_count;

        function new();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            node_count = NODE_COUNT_RESET;
            fail_count = 0;
        endfunction

        function void write_node_count(logic [CFG_W-1:0] value);
            node_count = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function int unsigned node_limit();
            return (node_count > NODES) ? NODES : node_count;
        endfunction

        // Set of nodes reachable from root, following only edges among nodes below lim.
        function logic [NODES-1:0] reach_from(int unsigned root, int unsigned lim);
            logic [NODES-1:0] mask;
            logic [NODES-1:0] reach;
            logic [NODES-1:0] grown;
            bit               changed;
            mask = (lim >= NODES) ? '1 : ((64'd1 << lim) - 64'd1);
            reach = '0;
            reach[root] = 1'b1;
            changed = 1'b1;
            while (changed)
            begin
                grown = reach;
                for (int u = 0; u < NODES; u++)
                    if (reach[u])
                        grown |= adj_rows[u] & mask;
                changed = (grown != reach);
                reach = grown;
            end
            return reach;
        endfunction

        // Applies one accepted input transaction and queues its answer, if any.
        function void note_item(logic [ACTION_W-1:0] act, logic [NODE_W-1:0] src,
                                logic [NODE_W-1:0] dst, logic [NODE_W-1:0] s_node,
                                logic [NODE_W-1:0] m_node, logic [NODE_W-1:0] e_node);
            int unsigned      lim;
            reach_result_t    res;
            logic [NODES-1:0] from_start;
            logic [NODES-1:0] from_middle;
            lim = node_limit();
            if (act == ACT_ADD)
            begin
                if (src < lim && dst < lim)
                    adj_rows[src][dst] = 1'b1;
            end
            else if (act == ACT_CLEAR)
            begin
                foreach (adj_rows[i])
                    adj_rows[i] = '0;
            end
            else if (act == ACT_QUERY)
            begin
                if (s_node >= lim || m_node >= lim || e_node >= lim)
                begin
                    res.path_exists = 1'b0;
                    res.node_error  = 1'b1;
                end
                else
                begin
                    from_start = reach_from(s_node, lim);
                    res.path_exists = 1'b0;
                    if (from_start[m_node])
                    begin
                        from_middle = reach_from(m_node, lim);
                        res.path_exists = from_middle[e_node];
                    end
                    res.node_error = 1'b0;
                end
                expected_q.push_back(res);
            end
        endfunction

        // Compares one output transaction with the oldest pending answer.
        function void check_result(logic path_exists, logic node_error);
            reach_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("output transaction with no query pending: path_exists %0b node_error %0b",
                       path_exists, node_error);
                fail_count++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (path_exists !== exp_res.path_exists)
            begin
                $error("path_exists mismatch: expected %0b, actual %0b",
                       exp_res.path_exists, path_exists);
                fail_count++;
            end
            if (node_error !== exp_res.node_error)
            begin
                $error("node_error mismatch: expected %0b, actual %0b",
                       exp_res.node_error, node_error);
                fail_count++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   edge_source;
    logic [NODE_W-1:0]   edge_dest;
    logic [NODE_W-1:0]   start_node;
    logic [NODE_W-1:0]   middle_node;
    logic [NODE_W-1:0]   end_node;
    logic                out_valid;
    logic                out_ready;
    logic                path_exists;
    logic                node_error;

    reach_scoreboard sb = new();

    graph_two_hop_reachability_unit #(
        .MAX_NODES(NODES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .edge_source (edge_source),
        .edge_dest   (edge_dest),
        .start_node  (start_node),
        .middle_node (middle_node),
        .end_node    (end_node),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .path_exists (path_exists),
        .node_error  (node_error)
    );

    always #10 clk = ~clk;

    // Presents one transaction at a falling edge and holds it until it is accepted.
    task automatic send_item(logic [ACTION_W-1:0] act, logic [NODE_W-1:0] src,
                             logic [NODE_W-1:0] dst, logic [NODE_W-1:0] s_node,
                             logic [NODE_W-1:0] m_node, logic [NODE_W-1:0] e_node);
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= act;
        edge_source <= src;
        edge_dest   <= dst;
        start_node  <= s_node;
        middle_node <= m_node;
        end_node    <= e_node;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(act, src, dst, s_node, m_node, e_node);
    endtask

    task automatic add_edge(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
        send_item(ACT_ADD, src, dst, NODE_W'($urandom), NODE_W'($urandom),
                  NODE_W'($urandom));
    endtask

    task automatic query_path(logic [NODE_W-1:0] s_node, logic [NODE_W-1:0] m_node,
                              logic [NODE_W-1:0] e_node);
        send_item(ACT_QUERY, NODE_W'($urandom), NODE_W'($urandom), s_node, m_node, e_node);
    endtask

    task automatic clear_graph();
        send_item(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                  NODE_W'($urandom), NODE_W'($urandom));
    endtask

    // Drops valid and pauses the sender; n (n >= 1) sets the length of the pause.
    task automatic pause_sender(int unsigned n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Holds the sender until every pending answer has come back and the unit is idle.
    task automatic drain_results();
        pause_sender(1);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_node_count(logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_node_count(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random phase: mostly edges inside the node range and queries over them.
    task automatic run_phase(logic [CFG_W-1:0] count, int unsigned n_items, bit wipe);
        int unsigned         lim;
        int unsigned         burst_left;
        int unsigned         roll;
        logic [ACTION_W-1:0] act;
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
        logic [NODE_W-1:0]   s_node;
        logic [NODE_W-1:0]   m_node;
        logic [NODE_W-1:0]   e_node;
        set_node_count(count);
        if (wipe)
            clear_graph();
        lim = (count > NODES) ? NODES : count;
        burst_left = $urandom_range(1, 40);
        for (int k = 0; k < n_items; k++)
        begin
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            src    = NODE_W'($urandom_range(0, NODES - 1));
            dst    = NODE_W'($urandom_range(0, NODES - 1));
            s_node = NODE_W'($urandom_range(0, NODES - 1));
            m_node = NODE_W'($urandom_range(0, NODES - 1));
            e_node = NODE_W'($urandom_range(0, NODES - 1));
            roll   = $urandom_range(0, 99);
            if (roll < 45)
            begin
                act = ACT_ADD;
                // Chain edges build long paths; the rest are random edges or out of range.
                if (lim > 0 && roll < 40)
                begin
                    src = NODE_W'($urandom_range(0, lim - 1));
                    if (roll < 20)
                        dst = NODE_W'((src + 1) % lim);
                    else
                        dst = NODE_W'($urandom_range(0, lim - 1));
                end
            end
            else if (roll < 47)
                act = ACT_CLEAR;
            else if (roll < 50)
                act = ACT_UNUSED;
            else
            begin
                act = ACT_QUERY;
                if (lim > 0 && roll < 93)
                begin
                    s_node = NODE_W'($urandom_range(0, lim - 1));
                    m_node = NODE_W'($urandom_range(0, lim - 1));
                    e_node = NODE_W'($urandom_range(0, lim - 1));
                end
            end
            send_item(act, src, dst, s_node, m_node, e_node);
        end
    endtask

    // Receiver: alternates between always ready, random stalls and a slow fixed pattern.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        out_ready = 1'b1;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            for (int t = 0; t < span; t++)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= (t % 6 == 5);
                endcase
            end
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(path_exists, node_error);
    end

    // Main stimulus.
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = NODE_COUNT_RESET;
        in_valid    = 1'b0;
        action      = ACT_ADD;
        edge_source = '0;
        edge_dest   = '0;
        start_node  = '0;
        middle_node = '0;
        end_node    = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Self reach on an empty graph, then a short path to the top node.
        query_path(0, 0, 0);
        query_path(0, 1, 1);
        add_edge(0, 1);
        add_edge(0, 1);
        add_edge(1, 63);
        add_edge(63, 62);
        query_path(0, 1, 63);
        query_path(0, 63, 62);
        query_path(62, 0, 0);
        send_item(ACT_UNUSED, '1, '1, '1, '1, '1);
        add_edge(63, 63);
        query_path(63, 63, 63);
        clear_graph();
        query_path(0, 1, 63);
        add_edge(2, 10);
        add_edge(10, 3);
        query_path(2, 10, 3);

        // Small node range: rejected edges, rejected queries and stale edges.
        set_node_count(7'd4);
        add_edge(5, 1);
        add_edge(1, 4);
        query_path(2, 3, 3);
        query_path(0, 0, 4);
        query_path(63, 0, 0);
        add_edge(0, 3);
        add_edge(3, 2);
        query_path(0, 3, 2);
        set_node_count(7'd0);
        query_path(0, 0, 0);
        set_node_count(7'd127);
        query_path(2, 10, 3);
        set_node_count(7'd1);
        query_path(0, 0, 0);

        // Random phases over a range of node counts.
        run_phase(7'd64, 150, 1'b0);
        run_phase(7'd8, 150, 1'b1);
        run_phase(7'd2, 150, 1'b0);
        run_phase(7'd64, 150, 1'b1);
        run_phase(7'd127, 150, 1'b0);
        run_phase(7'd16, 150, 1'b1);
        run_phase(7'd1, 100, 1'b0);
        run_phase(7'd0, 40, 1'b0);
        run_phase(7'd33, 150, 1'b1);
        run_phase(7'd5, 150, 1'b0);
        run_phase(CFG_W'($urandom_range(1, 64)), 150, 1'b1);
        run_phase(CFG_W'($urandom_range(65, 127)), 100, 1'b0);

        drain_results();
        repeat (END_CYCLES)
            @(negedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/gthr_pkg.sv
hw/rtl/graph_two_hop_reachability_unit.sv
dv/tb_graph_two_hop_reachability_unit.sv
